>>> hw/rtl/ipv6ctf_pkg.sv
// Package with the shared types, constants and helper functions of the IPv6 text formatter.
package ipv6ctf_pkg;

  localparam int unsigned NumHextets = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] CharColon = 7'h3a;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharLowerA = 7'h61;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic [NumHextets-1:0][15:0] hextet;
    logic [3:0]                  gap_start;
    logic [3:0]                  gap_len;
  } job_t;

  typedef struct packed {
    logic emit;
    logic pop;
  } back_stat_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] res;
    if (nib < 4'd10) begin
      res = CharZero + {3'b000, nib};
    end else begin
      res = CharLowerA + {3'b000, nib - 4'd10};
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/ipv6ctf_front.sv
// Front end: splits the address into hextets and finds the first longest zero run.
module ipv6ctf_front (
  input  ipv6ctf_pkg::in_t  in_data_i,
  output ipv6ctf_pkg::job_t job_o
);

  logic [ipv6ctf_pkg::NumHextets-1:0][15:0] hex;
  logic [3:0] run_start;
  logic [3:0] run_len;
  logic [3:0] best_start;
  logic [3:0] best_len;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hex[i]     = in_data_i.addr_hi[63 - 16 * i -: 16];
      hex[i + 4] = in_data_i.addr_lo[63 - 16 * i -: 16];
    end
  end

  always_comb begin
    run_start  = 4'd0;
    run_len    = 4'd0;
    best_start = 4'(ipv6ctf_pkg::NumHextets);
    best_len   = 4'd0;
    for (int i = 0; i < ipv6ctf_pkg::NumHextets; i++) begin
      if (hex[i] == 16'h0000) begin
        if (run_len == 4'd0) begin
          run_start = 4'(i);
        end
        run_len = run_len + 4'd1;
        if (run_len > best_len) begin
          best_len   = run_len;
          best_start = run_start;
        end
      end else begin
        run_len = 4'd0;
      end
    end
    if (best_len < 4'd2) begin
      best_start = 4'(ipv6ctf_pkg::NumHextets);
    end
  end

  always_comb begin
    job_o.hextet    = hex;
    job_o.gap_start = best_start;
    job_o.gap_len   = best_len;
  end

endmodule

>>> hw/rtl/ipv6ctf_queue.sv
// Small FIFO that carries classified addresses from the front end to the back end.
module ipv6ctf_queue #(
  parameter int unsigned Depth = ipv6ctf_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ipv6ctf_pkg::job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ipv6ctf_pkg::job_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ipv6ctf_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/ipv6ctf_back.sv
// Back end: character sequencer that writes one address text, one character per cycle while the output is not stalled.
module ipv6ctf_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  input  ipv6ctf_pkg::job_t       job_i,
  output logic                    job_pop_o,
  output logic                    out_valid_o,
  output ipv6ctf_pkg::out_t       out_data_o,
  input  logic                    out_ready_i,
  output ipv6ctf_pkg::back_stat_t stat_o
);

  typedef enum logic [1:0] {
    PhHead,
    PhDigit,
    PhGap2
  } phase_e;

  phase_e     ph_q, ph_d;
  logic [3:0] idx_q, idx_d;
  logic [1:0] nib_q, nib_d;
  logic       after_gap_q, after_gap_d;
  logic       out_valid_q;
  ipv6ctf_pkg::out_t out_q, out_d;

  logic        emit;
  logic        done;
  logic [15:0] cur_hex;
  logic [1:0]  lead;
  logic [1:0]  dig_pos;
  logic [3:0]  gap_end;
  logic        last_hex;

  assign emit     = job_valid_i && (!out_valid_q || out_ready_i);
  assign cur_hex  = job_i.hextet[idx_q[2:0]];
  assign gap_end  = idx_q + job_i.gap_len;
  assign last_hex = (idx_q == 4'(ipv6ctf_pkg::NumHextets - 1));

  always_comb begin
    if (cur_hex[15:12] != 4'h0) begin
      lead = 2'd3;
    end else if (cur_hex[11:8] != 4'h0) begin
      lead = 2'd2;
    end else if (cur_hex[7:4] != 4'h0) begin
      lead = 2'd1;
    end else begin
      lead = 2'd0;
    end
  end

  always_comb begin
    ph_d        = ph_q;
    idx_d       = idx_q;
    nib_d       = nib_q;
    after_gap_d = after_gap_q;
    done        = 1'b0;
    dig_pos     = nib_q;
    out_d.out_char  = ipv6ctf_pkg::CharColon;
    out_d.last_char = 1'b0;
    case (ph_q)
      PhHead: begin
        dig_pos = lead;
        if (idx_q == job_i.gap_start) begin
          out_d.out_char = ipv6ctf_pkg::CharColon;
          ph_d = PhGap2;
        end else if (idx_q != 4'd0 && !after_gap_q) begin
          out_d.out_char = ipv6ctf_pkg::CharColon;
          ph_d  = PhDigit;
          nib_d = lead;
        end else begin
          out_d.out_char = ipv6ctf_pkg::hex_char(cur_hex[{dig_pos, 2'b00} +: 4]);
          if (lead == 2'd0) begin
            idx_d       = idx_q + 4'd1;
            after_gap_d = 1'b0;
            done        = last_hex;
          end else begin
            ph_d  = PhDigit;
            nib_d = lead - 2'd1;
          end
        end
      end
      PhDigit: begin
        out_d.out_char = ipv6ctf_pkg::hex_char(cur_hex[{dig_pos, 2'b00} +: 4]);
        if (nib_q == 2'd0) begin
          ph_d        = PhHead;
          idx_d       = idx_q + 4'd1;
          after_gap_d = 1'b0;
          done        = last_hex;
        end else begin
          nib_d = nib_q - 2'd1;
        end
      end
      PhGap2: begin
        out_d.out_char = ipv6ctf_pkg::CharColon;
        ph_d        = PhHead;
        idx_d       = gap_end;
        after_gap_d = 1'b1;
        done        = (gap_end == 4'(ipv6ctf_pkg::NumHextets));
      end
      default: begin
        ph_d = PhHead;
      end
    endcase
    out_d.last_char = done;
    if (done) begin
      ph_d        = PhHead;
      idx_d       = 4'd0;
      nib_d       = 2'd0;
      after_gap_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PhHead;
      idx_q       <= 4'd0;
      nib_q       <= 2'd0;
      after_gap_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        ph_q        <= ph_d;
        idx_q       <= idx_d;
        nib_q       <= nib_d;
        after_gap_q <= after_gap_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign job_pop_o   = emit && done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign stat_o.emit = emit;
  assign stat_o.pop  = emit && done;

endmodule

>>> hw/rtl/ipv6_canonical_text_formatter_unit.sv
// Top level of the IPv6 canonical text formatter.
// Each accepted 128-bit address is written out as its canonical text, one ASCII character per
// output transfer, with the final character flagged by last_char. The output runs at one
// character per cycle while out_ready is not held low, a rate set by the single character
// sequencer in the back end; a text has from 2 characters for the all-zero address up to 39.
// The front end finds the zero run to compress in the cycle an address is taken and hands it
// to a small queue, so new addresses are taken while earlier text is still being sent. The
// back end registers the first character once the address is at the head of the queue and
// its output register is empty or being taken.
module ipv6_canonical_text_formatter_unit #(
  parameter int unsigned QueueDepth = ipv6ctf_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ipv6ctf_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ipv6ctf_pkg::out_t out_data_o
);

  ipv6ctf_pkg::job_t       new_job;
  ipv6ctf_pkg::job_t       head_job;
  ipv6ctf_pkg::back_stat_t back_stat;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;

  ipv6ctf_front u_front (
    .in_data_i (in_data_i),
    .job_o     (new_job)
  );

  ipv6ctf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (new_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_job)
  );

  ipv6ctf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_ready_i (out_ready_i),
    .stat_o      (back_stat)
  );

  assign in_ready_o = !q_full;

  // The sequencer only runs on a queued address.
  a_emit_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.emit |-> q_valid)
    else $error("character produced with an empty queue");

  // Retiring an address always leaves its final character in the output register.
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |=> (out_valid_o && out_data_o.last_char))
    else $error("address retired without a final character");

  // A character that is flagged as final retires the address in the same cycle.
  a_last_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_stat.emit && !back_stat.pop) |=> !out_data_o.last_char)
    else $error("final character flagged without retiring the address");

  // A produced character is always presented on the output.
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.emit |=> out_valid_o)
    else $error("produced character not presented");

endmodule

>>> bench/ipv6_text_checker.sv
// Checker that predicts the canonical IPv6 text of each address transfer and compares it.
module ipv6_text_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  ipv6ctf_pkg::in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  ipv6ctf_pkg::out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       chars_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  ipv6ctf_pkg::out_t expected_chars [$];
  ipv6ctf_pkg::out_t want;
  int unsigned       chars_seen;

  task automatic report_mismatch(input string what);
    if (fail_count_o < 100) begin
      $display("%0t mismatch at character %0d: %s", $realtime, chars_seen, what);
    end
    fail_count_o++;
  endtask

  function automatic void push_text_char(input logic [6:0] c);
    ipv6ctf_pkg::out_t ch;
    ch.out_char  = c;
    ch.last_char = 1'b0;
    expected_chars.push_back(ch);
  endfunction

  function automatic void format_address_text(input ipv6ctf_pkg::in_t addr);
    logic [127:0] word;
    logic [15:0]  hextet [ipv6ctf_pkg::NumHextets];
    logic [3:0]   nib;
    int           best_start, best_len, run_start, run_len, idx, shift;
    bit           after_gap, started;
    word = addr;
    for (idx = 0; idx < ipv6ctf_pkg::NumHextets; idx++) begin
      hextet[idx] = word[127 - 16 * idx -: 16];
    end
    best_start = ipv6ctf_pkg::NumHextets;
    best_len   = 0;
    run_start  = 0;
    run_len    = 0;
    for (idx = 0; idx < ipv6ctf_pkg::NumHextets; idx++) begin
      if (hextet[idx] == 16'h0) begin
        if (run_len == 0) begin
          run_start = idx;
        end
        run_len++;
        if (run_len > best_len) begin
          best_len   = run_len;
          best_start = run_start;
        end
      end else begin
        run_len = 0;
      end
    end
    if (best_len < 2) begin
      best_start = ipv6ctf_pkg::NumHextets;
    end
    idx       = 0;
    after_gap = 1'b0;
    while (idx < ipv6ctf_pkg::NumHextets) begin
      if (idx == best_start) begin
        push_text_char(ipv6ctf_pkg::CharColon);
        push_text_char(ipv6ctf_pkg::CharColon);
        idx       += best_len;
        after_gap = 1'b1;
      end else begin
        if (idx > 0 && !after_gap) begin
          push_text_char(ipv6ctf_pkg::CharColon);
        end
        after_gap = 1'b0;
        started   = 1'b0;
        for (shift = 12; shift >= 0; shift -= 4) begin
          nib = hextet[idx][shift +: 4];
          if (nib != 4'h0 || started || shift == 0) begin
            started = 1'b1;
            push_text_char(nib < 4'd10 ? ipv6ctf_pkg::CharZero + 7'(nib)
                                       : ipv6ctf_pkg::CharLowerA + 7'(nib - 4'd10));
          end
        end
        idx++;
      end
    end
    expected_chars[expected_chars.size() - 1].last_char = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer of 0x%0h", out_data_i.out_char));
        end else begin
          want = expected_chars.pop_front();
          if (out_data_i.out_char !== want.out_char) begin
            report_mismatch($sformatf("out_char 0x%0h, expected 0x%0h",
                                      out_data_i.out_char, want.out_char));
          end
          if (out_data_i.last_char !== want.last_char) begin
            report_mismatch($sformatf("last_char %b, expected %b",
                                      out_data_i.last_char, want.last_char));
          end
        end
        chars_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        format_address_text(in_data_i);
      end
    end
    chars_pending_o = expected_chars.size();
  end

endmodule

>>> bench/ipv6_canonical_text_formatter_unit_tb.sv
// Testbench top that drives addresses into the IPv6 text formatter and gives the verdict.
module ipv6_canonical_text_formatter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumDirected   = 22;
  localparam int RandomItems   = 200;
  localparam int HoldOffCycles = 400;
  localparam int IdleLimit     = 3000;
  localparam int DrainCycles   = 50;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  ipv6ctf_pkg::in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ipv6ctf_pkg::out_t out_data;
  int unsigned       fail_count;
  int unsigned       chars_pending;
  int unsigned       idle_cycles = 0;
  bit                hold_off_req  = 1'b0;
  bit                hold_off_done = 1'b0;

  logic [127:0] directed_addrs [NumDirected] = '{
    128'h0000_0000_0000_0000_0000_0000_0000_0000,
    128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff,
    128'h0000_0000_0000_0000_0000_0000_0000_0001,
    128'h0001_0000_0000_0000_0000_0000_0000_0000,
    128'h0001_0000_0000_0002_0000_0000_0003_0004,
    128'h0001_0000_0000_0002_0000_0000_0000_0003,
    128'h0001_0000_0002_0003_0004_0005_0006_0007,
    128'h0001_0002_0003_0004_0005_0006_0007_0000,
    128'h0000_0001_0002_0003_0004_0005_0006_0007,
    128'h0000_0000_0000_0000_0000_ffff_c0a8_0101,
    128'h0064_ff9b_0000_0000_0000_0000_c000_0201,
    128'h0001_0010_0100_1000_000a_00b0_0c00_d000,
    128'h0000_0001_0000_0001_0000_0001_0000_0001,
    128'h2001_0db8_0000_0000_0000_0000_0000_0001,
    128'hfe80_0000_0000_0000_0000_0000_0000_0000,
    128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
    128'hffff_ffff_ffff_ffff_0000_0000_0000_0000,
    128'h0000_0000_0000_0000_ffff_ffff_ffff_ffff,
    128'h0001_0002_0003_0000_0000_0004_0005_0006,
    128'h0000_0000_0001_0000_0000_0000_0001_0000,
    128'h0000_0000_0001_0002_0003_0004_0000_0000,
    128'h1000_0000_0000_0000_0000_0000_0000_0001
  };

  ipv6_canonical_text_formatter_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  ipv6_text_checker checker_inst (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .fail_count_o   (fail_count),
    .chars_pending_o(chars_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [127:0] random_address();
    logic [127:0] addr;
    int           kind, idx, run_start, run_len, pass;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      addr = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      for (idx = 0; idx < ipv6ctf_pkg::NumHextets; idx++) begin
        case ($urandom_range(0, 3))
          0: addr[127 - 16 * idx -: 16] = 16'h0;
          1: addr[127 - 16 * idx -: 16] = 16'($urandom_range(1, 15)) << (4 * $urandom_range(0, 3));
          default: addr[127 - 16 * idx -: 16] = 16'($urandom);
        endcase
      end
      for (pass = 0; pass < (kind >= 8 ? 2 : (kind >= 4 ? 1 : 0)); pass++) begin
        run_start = $urandom_range(0, ipv6ctf_pkg::NumHextets - 1);
        run_len   = $urandom_range(1, ipv6ctf_pkg::NumHextets - run_start);
        for (idx = run_start; idx < run_start + run_len; idx++) begin
          addr[127 - 16 * idx -: 16] = 16'h0;
        end
      end
    end
    return addr;
  endfunction

  task automatic send_address(input logic [127:0] addr);
    in_data  <= addr;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin : receiver
    int mode;
    int span;
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        repeat (HoldOffCycles) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int burst_left;
    int gap;
    int n;
    burst_left = $urandom_range(1, 12);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (n = 0; n < NumDirected + RandomItems; n++) begin
      if (n == NumDirected + 60) begin
        hold_off_req = 1'b1;
      end
      send_address(n < NumDirected ? directed_addrs[n] : random_address());
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    in_valid <= 1'b0;
    while (chars_pending != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
